// File: rtl/tbct_pkg.sv
// Shared types, constants and register map for the tick bar channel tracker.
// No dependencies; every other rtl file but tbct_checker refers to it by scoped names.
package tbct_pkg;

  localparam int unsigned BAR_DEPTH = 60;
  localparam int unsigned BAR_SLOTS = BAR_DEPTH + 1;
  localparam int unsigned BAR_AW    = $clog2(BAR_SLOTS);
  localparam int unsigned BAR_HW    = $clog2(BAR_SLOTS + 1);

  localparam int unsigned AVG_DEPTH = 8;
  localparam int unsigned AVG_IW    = $clog2(AVG_DEPTH);
  localparam int unsigned AVG_CW    = $clog2(AVG_DEPTH + 1);
  localparam int unsigned SUM_W     = 32 + $clog2(AVG_DEPTH);
  localparam int unsigned SUM_CW    = $clog2(SUM_W + 1);

  localparam int unsigned TICK_W    = 32;
  localparam int unsigned TICK_CW   = $clog2(TICK_W + 1);

  localparam int unsigned Q_DEPTH   = 2;
  localparam int unsigned Q_AW      = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW      = $clog2(Q_DEPTH + 1);

  localparam int unsigned NUM_CHAN  = 8;
  // channel slots: short group first, long group second
  localparam int unsigned CH_SHORT  = 0;
  localparam int unsigned CH_LONG   = 4;
  localparam int unsigned CH_MAX_HI = 0;
  localparam int unsigned CH_MIN_HI = 1;
  localparam int unsigned CH_MAX_LO = 2;
  localparam int unsigned CH_MIN_LO = 3;

  localparam logic [9:0] RST_BAR_TICKS    = 10'd5;
  localparam logic [5:0] RST_SHORT_WINDOW = 6'd30;
  localparam logic [5:0] RST_LONG_WINDOW  = 6'd50;
  localparam logic [5:0] RST_READY_BARS   = 6'd55;
  localparam logic [9:0] RST_MA_INTERVAL  = 10'd12;
  localparam logic [2:0] RST_MA_LENGTH    = 3'd5;

  typedef enum logic [2:0] {
    REG_BAR_TICKS    = 3'd0,
    REG_SHORT_WINDOW = 3'd1,
    REG_LONG_WINDOW  = 3'd2,
    REG_READY_BARS   = 3'd3,
    REG_MA_INTERVAL  = 3'd4,
    REG_MA_LENGTH    = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [9:0] bar_ticks;
    logic [5:0] short_window;
    logic [5:0] long_window;
    logic [5:0] ready_bars;
    logic [9:0] ma_interval;
    logic [2:0] ma_length;
  } cfg_t;

  typedef struct packed {
    logic [31:0] price;
    logic        opened;
    logic        sample;
  } qitem_t;

  typedef struct packed {
    logic                         bar_opened;
    logic                         channels_updated;
    logic [NUM_CHAN-1:0][31:0]    chan;
    logic [31:0]                  average;
    logic                         average_updated;
  } result_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SUM,
    B_DIV,
    B_SCAN,
    B_OUT
  } back_state_e;

endpackage

// File: rtl/tbct_front.sv
// Front end: accepts ticks, numbers them and classifies each as bar open / sample.
// Uses tbct_pkg; feeds tbct_fifo.
module tbct_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tbct_pkg::cfg_t   cfg_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [31:0]      price_i,
  output logic             push_o,
  output tbct_pkg::qitem_t item_o,
  input  logic             full_i
);

  tbct_pkg::front_state_e state_q, state_d;
  logic [31:0]                    tick_q;
  logic [31:0]                    shift_q;
  logic [31:0]                    price_q;
  logic                           idx_zero_q;
  logic [9:0]                     rem_b_q, rem_m_q, rem_b_d, rem_m_d;
  logic [tbct_pkg::TICK_CW-1:0]   cnt_q;
  logic [9:0]                     div_b, div_m;
  logic [10:0]                    try_b, try_m;
  logic                           accept;

  assign div_b  = (cfg_i.bar_ticks == '0) ? 10'd1 : cfg_i.bar_ticks;
  assign div_m  = (cfg_i.ma_interval == '0) ? 10'd1 : cfg_i.ma_interval;
  assign accept = in_valid_i && (state_q == tbct_pkg::F_IDLE);
  assign in_stall_o = (state_q != tbct_pkg::F_IDLE);

  // one remainder bit per cycle for both divisors
  always_comb begin
    try_b = {rem_b_q, shift_q[31]};
    try_m = {rem_m_q, shift_q[31]};
    rem_b_d = (try_b >= {1'b0, div_b}) ? 10'(try_b - {1'b0, div_b}) : try_b[9:0];
    rem_m_d = (try_m >= {1'b0, div_m}) ? 10'(try_m - {1'b0, div_m}) : try_m[9:0];
  end

  always_comb begin
    state_d = state_q;
    push_o  = 1'b0;
    case (state_q)
      tbct_pkg::F_IDLE: begin
        if (accept) state_d = tbct_pkg::F_DIV;
      end
      tbct_pkg::F_DIV: begin
        if (cnt_q == tbct_pkg::TICK_CW'(1)) state_d = tbct_pkg::F_PUSH;
      end
      tbct_pkg::F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = tbct_pkg::F_IDLE;
        end
      end
      default: state_d = tbct_pkg::F_IDLE;
    endcase
  end

  assign item_o.price  = price_q;
  assign item_o.opened = (rem_b_q == '0);
  assign item_o.sample = !idx_zero_q && (rem_m_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tbct_pkg::F_IDLE;
      tick_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        tick_q <= tick_q + 32'd1;
        cnt_q  <= tbct_pkg::TICK_CW'(tbct_pkg::TICK_W);
      end else if (state_q == tbct_pkg::F_DIV) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      price_q    <= price_i;
      shift_q    <= tick_q;
      idx_zero_q <= (tick_q == '0);
      rem_b_q    <= '0;
      rem_m_q    <= '0;
    end else if (state_q == tbct_pkg::F_DIV) begin
      shift_q <= {shift_q[30:0], 1'b0};
      rem_b_q <= rem_b_d;
      rem_m_q <= rem_m_d;
    end
  end

endmodule

// File: rtl/tbct_fifo.sv
// Short queue of classified ticks between front and back end.
// Uses tbct_pkg.
module tbct_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tbct_pkg::qitem_t item_i,
  output logic             full_o,
  input  logic             pop_i,
  output tbct_pkg::qitem_t item_o,
  output logic             valid_o
);

  tbct_pkg::qitem_t            mem_q [tbct_pkg::Q_DEPTH];
  logic [tbct_pkg::Q_AW-1:0]   wr_q, rd_q;
  logic [tbct_pkg::Q_CW-1:0]   cnt_q;

  assign full_o  = (cnt_q == tbct_pkg::Q_CW'(tbct_pkg::Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == tbct_pkg::Q_AW'(tbct_pkg::Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == tbct_pkg::Q_AW'(tbct_pkg::Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

endmodule

// File: rtl/tbct_back.sv
// Back end: sample window and average, bar store, channel scan, result register.
// Uses tbct_pkg; fed by tbct_fifo.
module tbct_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tbct_pkg::cfg_t     cfg_i,
  input  logic               item_valid_i,
  input  tbct_pkg::qitem_t   item_i,
  output logic               pop_o,
  output logic               res_valid_o,
  output tbct_pkg::result_t  res_o,
  input  logic               res_stall_i
);

  tbct_pkg::back_state_e state_q, state_d;

  logic [31:0]                  samples_q [tbct_pkg::AVG_DEPTH];
  logic [31:0]                  samples_a [tbct_pkg::AVG_DEPTH];
  logic [31:0]                  samples_b [tbct_pkg::AVG_DEPTH];
  logic [31:0]                  samples_c [tbct_pkg::AVG_DEPTH];
  logic [tbct_pkg::AVG_CW-1:0]  held_q, held_a, held_b, held_c;
  logic                         need_avg;
  logic [tbct_pkg::AVG_IW-1:0]  sum_idx_q;
  logic [tbct_pkg::SUM_W-1:0]   sum_q, quo_n;
  logic [2:0]                   rem_q, rem_n, ml_eff;
  logic [3:0]                   rem_try;
  logic                         rem_ge;
  logic [tbct_pkg::SUM_CW-1:0]  div_cnt_q;
  logic [31:0]                  avg_q;

  logic [tbct_pkg::BAR_HW-1:0]  bars_held_q, bars_held_n;
  logic [tbct_pkg::BAR_AW-1:0]  newest_q, newest_n, ptr_q, age1_slot;
  logic [31:0]                  cur_hi_q, cur_lo_q, hi_n, lo_n;
  logic                         bar_we;
  logic [63:0]                  bar_mem [tbct_pkg::BAR_SLOTS];
  logic [63:0]                  rd_q;

  logic                         chan_n, s_ok, l_ok;
  logic [5:0]                   ws, wl, limit;
  logic [5:0]                   ws_q, wl_q, limit_q;
  logic                         s_ok_q, l_ok_q, scan_go_q;
  logic [tbct_pkg::BAR_HW-1:0]  iss_age_q, rd_age_q;
  logic                         rd_vld_q;
  logic [tbct_pkg::NUM_CHAN-1:0][31:0] acc_q, acc_n, chan_q;
  logic [31:0]                  rd_hi, rd_lo;

  logic                         opened_q, chan_upd_q, avg_upd_q;
  tbct_pkg::result_t            res_q;
  logic                         res_vld_q, out_load, take;

  assign take        = (state_q == tbct_pkg::B_IDLE) && item_valid_i;
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;
  assign ml_eff      = (cfg_i.ma_length == '0) ? 3'd1 : cfg_i.ma_length;

  // sample window update for the item at the queue head
  always_comb begin
    samples_a = samples_q;
    held_a    = held_q;
    if (item_i.sample && (32'(held_q) >= tbct_pkg::AVG_DEPTH)) begin
      for (int i = 0; i < tbct_pkg::AVG_DEPTH - 1; i++) samples_a[i] = samples_q[i + 1];
      held_a = held_q - 1'b1;
    end
    samples_b = samples_a;
    held_b    = held_a;
    if (item_i.sample) begin
      samples_b[held_a[tbct_pkg::AVG_IW-1:0]] = item_i.price;
      held_b = held_a + 1'b1;
    end
    need_avg  = item_i.sample && (32'(held_b) > 32'(ml_eff));
    samples_c = samples_b;
    held_c    = held_b;
    if (need_avg) begin
      for (int i = 0; i < tbct_pkg::AVG_DEPTH - 1; i++) samples_c[i] = samples_b[i + 1];
      held_c = held_b - 1'b1;
    end
  end

  // bar update and channel setup
  always_comb begin
    newest_n    = newest_q;
    bars_held_n = bars_held_q;
    hi_n        = cur_hi_q;
    lo_n        = cur_lo_q;
    bar_we      = 1'b0;
    if (!item_i.opened) begin
      if (bars_held_q != '0) begin
        if (item_i.price > cur_hi_q) hi_n = item_i.price;
        if (item_i.price < cur_lo_q) lo_n = item_i.price;
        bar_we = 1'b1;
      end
    end else begin
      if (bars_held_q != '0) begin
        newest_n = (newest_q == tbct_pkg::BAR_AW'(tbct_pkg::BAR_DEPTH)) ? '0
                                                                      : newest_q + 1'b1;
      end
      hi_n   = item_i.price;
      lo_n   = item_i.price;
      bar_we = 1'b1;
      if (32'(bars_held_q) < tbct_pkg::BAR_SLOTS) bars_held_n = bars_held_q + 1'b1;
    end
    age1_slot = (newest_n == '0) ? tbct_pkg::BAR_AW'(tbct_pkg::BAR_DEPTH) : newest_n - 1'b1;
    chan_n = item_i.opened && (32'(bars_held_n) > 32'(cfg_i.ready_bars));
    ws     = (cfg_i.short_window == '0) ? 6'd1 : cfg_i.short_window;
    wl     = (cfg_i.long_window == '0) ? 6'd1 : cfg_i.long_window;
    s_ok   = 32'(ws) < 32'(bars_held_n);
    l_ok   = 32'(wl) < 32'(bars_held_n);
    limit  = '0;
    if (s_ok) limit = ws;
    if (l_ok && (wl > limit)) limit = wl;
  end

  // restoring divide step, quotient shifts into the sum register
  always_comb begin
    rem_try = {rem_q, sum_q[tbct_pkg::SUM_W-1]};
    rem_ge  = (rem_try >= {1'b0, ml_eff});
    rem_n   = rem_ge ? 3'(rem_try - {1'b0, ml_eff}) : rem_try[2:0];
    quo_n   = {sum_q[tbct_pkg::SUM_W-2:0], rem_ge};
  end

  // channel accumulators
  always_comb begin
    rd_hi = rd_q[63:32];
    rd_lo = rd_q[31:0];
    acc_n = acc_q;
    if (rd_age_q == tbct_pkg::BAR_HW'(1)) begin
      acc_n[tbct_pkg::CH_SHORT + tbct_pkg::CH_MAX_HI] = rd_hi;
      acc_n[tbct_pkg::CH_SHORT + tbct_pkg::CH_MIN_HI] = rd_hi;
      acc_n[tbct_pkg::CH_SHORT + tbct_pkg::CH_MAX_LO] = rd_lo;
      acc_n[tbct_pkg::CH_SHORT + tbct_pkg::CH_MIN_LO] = rd_lo;
      acc_n[tbct_pkg::CH_LONG + tbct_pkg::CH_MAX_HI]  = rd_hi;
      acc_n[tbct_pkg::CH_LONG + tbct_pkg::CH_MIN_HI]  = rd_hi;
      acc_n[tbct_pkg::CH_LONG + tbct_pkg::CH_MAX_LO]  = rd_lo;
      acc_n[tbct_pkg::CH_LONG + tbct_pkg::CH_MIN_LO]  = rd_lo;
    end else begin
      if (32'(rd_age_q) <= 32'(ws_q)) begin
        if (rd_hi > acc_q[tbct_pkg::CH_SHORT + tbct_pkg::CH_MAX_HI])
          acc_n[tbct_pkg::CH_SHORT + tbct_pkg::CH_MAX_HI] = rd_hi;
        if (rd_hi < acc_q[tbct_pkg::CH_SHORT + tbct_pkg::CH_MIN_HI])
          acc_n[tbct_pkg::CH_SHORT + tbct_pkg::CH_MIN_HI] = rd_hi;
        if (rd_lo > acc_q[tbct_pkg::CH_SHORT + tbct_pkg::CH_MAX_LO])
          acc_n[tbct_pkg::CH_SHORT + tbct_pkg::CH_MAX_LO] = rd_lo;
        if (rd_lo < acc_q[tbct_pkg::CH_SHORT + tbct_pkg::CH_MIN_LO])
          acc_n[tbct_pkg::CH_SHORT + tbct_pkg::CH_MIN_LO] = rd_lo;
      end
      if (32'(rd_age_q) <= 32'(wl_q)) begin
        if (rd_hi > acc_q[tbct_pkg::CH_LONG + tbct_pkg::CH_MAX_HI])
          acc_n[tbct_pkg::CH_LONG + tbct_pkg::CH_MAX_HI] = rd_hi;
        if (rd_hi < acc_q[tbct_pkg::CH_LONG + tbct_pkg::CH_MIN_HI])
          acc_n[tbct_pkg::CH_LONG + tbct_pkg::CH_MIN_HI] = rd_hi;
        if (rd_lo > acc_q[tbct_pkg::CH_LONG + tbct_pkg::CH_MAX_LO])
          acc_n[tbct_pkg::CH_LONG + tbct_pkg::CH_MAX_LO] = rd_lo;
        if (rd_lo < acc_q[tbct_pkg::CH_LONG + tbct_pkg::CH_MIN_LO])
          acc_n[tbct_pkg::CH_LONG + tbct_pkg::CH_MIN_LO] = rd_lo;
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    out_load = 1'b0;
    case (state_q)
      tbct_pkg::B_IDLE: begin
        if (item_valid_i) begin
          pop_o = 1'b1;
          if (need_avg) state_d = tbct_pkg::B_SUM;
          else if (chan_n && (s_ok || l_ok)) state_d = tbct_pkg::B_SCAN;
          else state_d = tbct_pkg::B_OUT;
        end
      end
      tbct_pkg::B_SUM: begin
        if (32'(sum_idx_q) + 32'd1 == 32'(held_q)) state_d = tbct_pkg::B_DIV;
      end
      tbct_pkg::B_DIV: begin
        if (div_cnt_q == tbct_pkg::SUM_CW'(1)) begin
          state_d = scan_go_q ? tbct_pkg::B_SCAN : tbct_pkg::B_OUT;
        end
      end
      tbct_pkg::B_SCAN: begin
        if (rd_vld_q && (32'(rd_age_q) == 32'(limit_q))) state_d = tbct_pkg::B_OUT;
      end
      tbct_pkg::B_OUT: begin
        if (!res_vld_q || !res_stall_i) begin
          out_load = 1'b1;
          state_d  = tbct_pkg::B_IDLE;
        end
      end
      default: state_d = tbct_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tbct_pkg::B_IDLE;
      held_q      <= '0;
      avg_q       <= '0;
      bars_held_q <= '0;
      newest_q    <= '0;
      chan_q      <= '0;
      res_vld_q   <= 1'b0;
      rd_vld_q    <= 1'b0;
      scan_go_q   <= 1'b0;
      sum_idx_q   <= '0;
      div_cnt_q   <= '0;
      iss_age_q   <= '0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= 1'b0;
      if (take) begin
        held_q      <= held_c;
        bars_held_q <= bars_held_n;
        newest_q    <= newest_n;
        scan_go_q   <= chan_n && (s_ok || l_ok);
        sum_idx_q   <= '0;
        iss_age_q   <= tbct_pkg::BAR_HW'(1);
      end
      if (state_q == tbct_pkg::B_SUM) begin
        sum_idx_q <= sum_idx_q + 1'b1;
        div_cnt_q <= tbct_pkg::SUM_CW'(tbct_pkg::SUM_W);
      end
      if (state_q == tbct_pkg::B_DIV) begin
        div_cnt_q <= div_cnt_q - 1'b1;
        if (div_cnt_q == tbct_pkg::SUM_CW'(1)) begin
          avg_q <= (|quo_n[tbct_pkg::SUM_W-1:32]) ? '1 : quo_n[31:0];
        end
      end
      if ((state_q == tbct_pkg::B_SCAN) && (32'(iss_age_q) <= 32'(limit_q))) begin
        rd_vld_q  <= 1'b1;
        iss_age_q <= iss_age_q + 1'b1;
      end
      if ((state_q == tbct_pkg::B_SCAN) && (state_d == tbct_pkg::B_OUT)) begin
        for (int i = 0; i < 4; i++) begin
          if (s_ok_q) chan_q[tbct_pkg::CH_SHORT + i] <= acc_n[tbct_pkg::CH_SHORT + i];
          if (l_ok_q) chan_q[tbct_pkg::CH_LONG + i]  <= acc_n[tbct_pkg::CH_LONG + i];
        end
      end
      if (out_load) res_vld_q <= 1'b1;
      else if (!res_stall_i) res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      samples_q  <= samples_c;
      opened_q   <= item_i.opened;
      chan_upd_q <= chan_n;
      avg_upd_q  <= need_avg;
      ws_q       <= ws;
      wl_q       <= wl;
      s_ok_q     <= s_ok;
      l_ok_q     <= l_ok;
      limit_q    <= limit;
      ptr_q      <= age1_slot;
      sum_q      <= '0;
      if (bar_we) begin
        cur_hi_q <= hi_n;
        cur_lo_q <= lo_n;
      end
    end
    if (state_q == tbct_pkg::B_SUM) begin
      sum_q <= sum_q + tbct_pkg::SUM_W'(samples_q[sum_idx_q]);
      rem_q <= '0;
    end
    if (state_q == tbct_pkg::B_DIV) begin
      sum_q <= quo_n;
      rem_q <= rem_n;
    end
    if ((state_q == tbct_pkg::B_SCAN) && (32'(iss_age_q) <= 32'(limit_q))) begin
      rd_age_q <= iss_age_q;
      ptr_q    <= (ptr_q == '0) ? tbct_pkg::BAR_AW'(tbct_pkg::BAR_DEPTH) : ptr_q - 1'b1;
    end
    if (rd_vld_q) acc_q <= acc_n;
    if (out_load) begin
      res_q.bar_opened       <= opened_q;
      res_q.channels_updated <= chan_upd_q;
      res_q.chan             <= chan_q;
      res_q.average          <= avg_q;
      res_q.average_updated  <= avg_upd_q;
    end
  end

  // bar store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (take && bar_we) bar_mem[newest_n] <= {hi_n, lo_n};
    rd_q <= bar_mem[ptr_q];
  end

endmodule

// File: rtl/tick_bar_channel_tracker.sv
// Top level of the tick bar channel tracker: register port, front, queue, back.
// Uses tbct_pkg, tbct_front, tbct_fifo and tbct_back.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------------
//   tick in | input     | in_valid_i / in_stall_o   | price_i
//   result  | output    | out_valid_o / out_stall_i | bar/channel/average fields
//   config  | input     | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// The front takes a new tick only once the last one is pushed to the queue: the
// bar and sample remainders of the tick index are formed one bit per cycle.
// The back takes one queued tick at a time: a plain tick goes straight to the
// output register, a tick that yields an average first sums the held samples
// and divides, and one recomputing channels scans the bar store through its
// single read port. Reset clears all control state; no clearing pass is needed.
// A stalled result holds in the output register while the queue keeps filling.
module tick_bar_channel_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] price_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        bar_opened_o,
  output logic        channels_updated_o,
  output logic [31:0] short_max_high_o,
  output logic [31:0] short_min_high_o,
  output logic [31:0] short_max_low_o,
  output logic [31:0] short_min_low_o,
  output logic [31:0] long_max_high_o,
  output logic [31:0] long_min_high_o,
  output logic [31:0] long_max_low_o,
  output logic [31:0] long_min_low_o,
  output logic [31:0] average_price_o,
  output logic        average_updated_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tbct_pkg::cfg_t     cfg_q;
  tbct_pkg::reg_idx_e reg_sel;
  tbct_pkg::qitem_t   front_item, q_item;
  tbct_pkg::result_t  res;
  logic               push, full, pop, q_valid;

  assign pready  = 1'b1;
  assign reg_sel = tbct_pkg::reg_idx_e'(paddr[4:2]);

  // register writes complete in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bar_ticks    <= tbct_pkg::RST_BAR_TICKS;
      cfg_q.short_window <= tbct_pkg::RST_SHORT_WINDOW;
      cfg_q.long_window  <= tbct_pkg::RST_LONG_WINDOW;
      cfg_q.ready_bars   <= tbct_pkg::RST_READY_BARS;
      cfg_q.ma_interval  <= tbct_pkg::RST_MA_INTERVAL;
      cfg_q.ma_length    <= tbct_pkg::RST_MA_LENGTH;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        tbct_pkg::REG_BAR_TICKS:    cfg_q.bar_ticks    <= pwdata[9:0];
        tbct_pkg::REG_SHORT_WINDOW: cfg_q.short_window <= pwdata[5:0];
        tbct_pkg::REG_LONG_WINDOW:  cfg_q.long_window  <= pwdata[5:0];
        tbct_pkg::REG_READY_BARS:   cfg_q.ready_bars   <= pwdata[5:0];
        tbct_pkg::REG_MA_INTERVAL:  cfg_q.ma_interval  <= pwdata[9:0];
        tbct_pkg::REG_MA_LENGTH:    cfg_q.ma_length    <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      tbct_pkg::REG_BAR_TICKS:    prdata = 32'(cfg_q.bar_ticks);
      tbct_pkg::REG_SHORT_WINDOW: prdata = 32'(cfg_q.short_window);
      tbct_pkg::REG_LONG_WINDOW:  prdata = 32'(cfg_q.long_window);
      tbct_pkg::REG_READY_BARS:   prdata = 32'(cfg_q.ready_bars);
      tbct_pkg::REG_MA_INTERVAL:  prdata = 32'(cfg_q.ma_interval);
      tbct_pkg::REG_MA_LENGTH:    prdata = 32'(cfg_q.ma_length);
      default:                    prdata = '0;
    endcase
  end

  // number and classify each tick
  tbct_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .price_i    (price_i),
    .push_o     (push),
    .item_o     (front_item),
    .full_i     (full)
  );

  // decouple classification from the long back end work
  tbct_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (q_item),
    .valid_o (q_valid)
  );

  // average, bar store, channel scan and result register
  tbct_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .pop_o        (pop),
    .res_valid_o  (out_valid_o),
    .res_o        (res),
    .res_stall_i  (out_stall_i)
  );

  assign bar_opened_o       = res.bar_opened;
  assign channels_updated_o = res.channels_updated;
  assign short_max_high_o   = res.chan[tbct_pkg::CH_SHORT + tbct_pkg::CH_MAX_HI];
  assign short_min_high_o   = res.chan[tbct_pkg::CH_SHORT + tbct_pkg::CH_MIN_HI];
  assign short_max_low_o    = res.chan[tbct_pkg::CH_SHORT + tbct_pkg::CH_MAX_LO];
  assign short_min_low_o    = res.chan[tbct_pkg::CH_SHORT + tbct_pkg::CH_MIN_LO];
  assign long_max_high_o    = res.chan[tbct_pkg::CH_LONG + tbct_pkg::CH_MAX_HI];
  assign long_min_high_o    = res.chan[tbct_pkg::CH_LONG + tbct_pkg::CH_MIN_HI];
  assign long_max_low_o     = res.chan[tbct_pkg::CH_LONG + tbct_pkg::CH_MAX_LO];
  assign long_min_low_o     = res.chan[tbct_pkg::CH_LONG + tbct_pkg::CH_MIN_LO];
  assign average_price_o    = res.average;
  assign average_updated_o  = res.average_updated;

endmodule

// File: rtl/tbct_checker.sv
// Port-level checks for the tick bar channel tracker, bound to the top level.
// Depends on tick_bar_channel_tracker's port list only.
module tbct_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        bar_opened_o,
  input logic        channels_updated_o,
  input logic [31:0] average_price_o
);

  logic [3:0] pend_q;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_beat = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_beat && !out_beat) begin
      pend_q <= pend_q + 1'b1;
    end else if (out_beat && !in_beat) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  a_no_invented_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> (pend_q != '0))
    else $error("result beat without a pending tick");

  a_bounded_inflight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 4'd5)
    else $error("more ticks in flight than the pipeline holds");

  a_chan_needs_open : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && channels_updated_o) |-> bar_opened_o)
    else $error("channel update on a tick that opened no bar");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(average_price_o)))
    else $error("stalled result changed");

endmodule

bind tick_bar_channel_tracker tbct_checker u_tbct_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .bar_opened_o       (bar_opened_o),
  .channels_updated_o (channels_updated_o),
  .average_price_o    (average_price_o)
);
